// File: rtl/core/eutc_pkg.sv
package eutc_pkg;

  // 86400 seconds per day = 675 * 2^7
  localparam int unsigned DAY_ODD   = 675;
  localparam int          DAY_SHIFT = 7;
  localparam int          ODD_W     = 10;
  localparam int          SOD_W     = 17;

  // Day counts of the Gregorian cycles, years starting on March 1
  localparam int unsigned DAYS_1600_TO_1970 = 135080;
  localparam int unsigned DAYS_400Y         = 146097;
  localparam int unsigned DAYS_CENTURY      = 36524;
  localparam int unsigned DAYS_4Y           = 1461;
  localparam int unsigned DAYS_YEAR         = 365;

  // Year assembly
  localparam int unsigned YEARS_PER_400 = 400;
  localparam int unsigned YEARS_PER_CEN = 100;
  localparam int unsigned YEAR_BIAS     = 300;  // 1900 - 1600
  localparam logic [15:0] YEAR_MAX      = 16'hFFFF;

  // Weekday: 1970-01-01 was a Thursday
  localparam int unsigned EPOCH_WDAY = 4;
  localparam int unsigned WEEK_DAYS  = 7;

  // Leap day markers and month mapping
  localparam logic [2:0] CENT_LEAP  = 3'd4;
  localparam logic [2:0] YRS_LEAP   = 3'd4;
  localparam logic [4:0] LEAP_MDAY  = 5'd29;
  localparam logic [3:0] MARCH_OFS  = 4'd2;
  localparam logic [3:0] JAN_WRAP   = 4'd10;
  localparam logic [3:0] MON_FEB    = 4'd1;
  localparam logic [3:0] MON_APR    = 4'd3;
  localparam logic [3:0] MON_JUN    = 4'd5;
  localparam logic [3:0] MON_SEP    = 4'd8;
  localparam logic [3:0] MON_NOV    = 4'd10;

  // First day of each month within a March-based year
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
  } date_t;

endpackage

// File: rtl/core/epoch_seconds_to_utc_calendar_unit.sv
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 UTC into
// the UTC calendar date and time. A new timestamp is taken on every cycle
// that start_i is high (busy_o stays low), and each result shows on the
// output ports for exactly one cycle with done_o high; results leave in
// the order the timestamps came in and the receiver cannot hold them off.
// Each timestamp passes through the input register, the two constant
// dividers of the split into days, the rebase register, the four
// dividers for the 400-year, century, 4-year and year cycles, and the
// output register. Years beyond 65535 + 1900 read as 65535.
module epoch_seconds_to_utc_calendar_unit import eutc_pkg::*; #(
  parameter int EPOCH_BITS = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [EPOCH_BITS-1:0] epoch_seconds_i,
  output logic                  done_o,
  output logic [5:0]            second_of_minute_o,
  output logic [5:0]            minute_of_hour_o,
  output logic [4:0]            hour_of_day_o,
  output logic [2:0]            weekday_o,
  output logic [15:0]           year_since_1900_o,
  output logic [3:0]            month_index_o,
  output logic [4:0]            day_of_month_o
);

  localparam int DW         = EPOCH_BITS - 16;
  localparam int PIPE_DEPTH = 14;
  localparam int TOD_ALIGN  = 5;

  logic [PIPE_DEPTH-1:0]  vld_q;
  logic                   done_q;
  logic [EPOCH_BITS-1:0]  t_q;
  logic [DW-1:0]          days;
  logic [SOD_W-1:0]       sod;
  tod_t                   tod;
  tod_t                   tod_dly_q [TOD_ALIGN];
  date_t                  date;
  tod_t                   res_tod_q;
  date_t                  res_date_q;

  assign busy_o = 1'b0;

  // transfer tracking down the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[PIPE_DEPTH-2:0], start_i & ~busy_o};
      done_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    t_q <= epoch_seconds_i;
  end

  eutc_day_split #(
    .EB(EPOCH_BITS)
  ) u_day_split (
    .clk_i  (clk_i),
    .t_i    (t_q),
    .days_o (days),
    .sod_o  (sod)
  );

  eutc_tod u_tod (
    .clk_i (clk_i),
    .sod_i (sod),
    .tod_o (tod)
  );

  eutc_civil #(
    .DW(DW)
  ) u_civil (
    .clk_i  (clk_i),
    .days_i (days),
    .date_o (date)
  );

  // time of day finishes early; hold it until the date is ready
  always_ff @(posedge clk_i) begin
    tod_dly_q[0] <= tod;
    for (int k = 1; k < TOD_ALIGN; k++) begin
      tod_dly_q[k] <= tod_dly_q[k-1];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    res_tod_q  <= tod_dly_q[TOD_ALIGN-1];
    res_date_q <= date;
  end

  assign done_o             = done_q;
  assign second_of_minute_o = res_tod_q.second;
  assign minute_of_hour_o   = res_tod_q.minute;
  assign hour_of_day_o      = res_tod_q.hour;
  assign weekday_o          = res_date_q.wday;
  assign year_since_1900_o  = res_date_q.year;
  assign month_index_o      = res_date_q.month;
  assign day_of_month_o     = res_date_q.mday;

`ifndef ASSERT_OFF
  a_done_has_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, PIPE_DEPTH + 1))
    else $error("result strobe without a matching transfer");

  a_transfer_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(PIPE_DEPTH + 1) done_o)
    else $error("transfer did not produce a result");

  a_fields_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (second_of_minute_o < 6'd60) && (minute_of_hour_o < 6'd60) &&
               (hour_of_day_o < 5'd24) && (weekday_o < 3'd7) &&
               (month_index_o < 4'd12) && (day_of_month_o != 5'd0))
    else $error("result field out of range");

  a_leap_day_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (month_index_o == MON_FEB) && (day_of_month_o >= LEAP_MDAY)) |->
      (day_of_month_o == LEAP_MDAY) &&
      ((year_since_1900_o[1:0] == 2'b00) || (year_since_1900_o == YEAR_MAX)))
    else $error("February day past 28 in a non-leap year");

  a_short_months: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (day_of_month_o == 5'd31)) |->
      (month_index_o != MON_FEB) && (month_index_o != MON_APR) &&
      (month_index_o != MON_JUN) && (month_index_o != MON_SEP) &&
      (month_index_o != MON_NOV))
    else $error("day 31 in a short month");
`endif

endmodule

// File: rtl/core/eutc_cdiv.sv
// Two-stage divider by a constant: reciprocal multiply, then one
// back-multiply and a single correction step. Side-band bits travel along.
module eutc_cdiv #(
  parameter int          XW  = 16,
  parameter int unsigned D   = 3,
  parameter int          QW  = 8,
  parameter int          RW  = 2,
  parameter int          SBW = 1
) (
  input  logic           clk_i,
  input  logic [XW-1:0]  x_i,
  input  logic [SBW-1:0] sb_i,
  output logic [QW-1:0]  q_o,
  output logic [RW-1:0]  r_o,
  output logic [SBW-1:0] sb_o
);

  localparam int          MW         = XW - $clog2(D) + 2;
  localparam int          PW         = XW + MW;
  localparam logic [XW:0] POW2       = {1'b1, {XW{1'b0}}};
  localparam logic [XW:0] RECIP_FULL = POW2 / (XW+1)'(D);
  localparam logic [MW-1:0] RECIP    = RECIP_FULL[MW-1:0];
  localparam logic [XW-1:0] DIV      = XW'(D);

  logic [PW-1:0]  prod_q;
  logic [XW-1:0]  x_q;
  logic [SBW-1:0] sb1_q;

  logic [MW-1:0]  qe;
  logic [XW-1:0]  back;
  logic [XW-1:0]  rem_raw;
  logic           fix;
  logic [MW-1:0]  q_d;
  logic [XW-1:0]  r_d;

  logic [QW-1:0]  q_q;
  logic [RW-1:0]  r_q;
  logic [SBW-1:0] sb2_q;

  // stage 1: estimate, low by at most one
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(x_i) * PW'(RECIP);
    x_q    <= x_i;
    sb1_q  <= sb_i;
  end

  // stage 2: remainder and correction
  always_comb begin
    qe      = prod_q[PW-1:XW];
    back    = XW'(qe) * DIV;
    rem_raw = x_q - back;
    fix     = rem_raw >= DIV;
    q_d     = fix ? qe + MW'(1) : qe;
    r_d     = fix ? rem_raw - DIV : rem_raw;
  end

  always_ff @(posedge clk_i) begin
    q_q   <= QW'(q_d);
    r_q   <= RW'(r_d);
    sb2_q <= sb1_q;
  end

  assign q_o  = q_q;
  assign r_o  = r_q;
  assign sb_o = sb2_q;

endmodule

// File: rtl/core/eutc_day_split.sv
// Seconds to whole days and second of day, as two chained divisions by 675
// of the seconds count with its low 7 bits set aside.
module eutc_day_split import eutc_pkg::*; #(
  parameter int EB = 40
) (
  input  logic             clk_i,
  input  logic [EB-1:0]    t_i,
  output logic [EB-17:0]   days_o,
  output logic [SOD_W-1:0] sod_o
);

  localparam int HI_W = 19;
  localparam int LW   = EB - HI_W - DAY_SHIFT;
  localparam int LOW  = LW + DAY_SHIFT;
  localparam int SBB  = ODD_W + DAY_SHIFT;

  logic [ODD_W-1:0] q1;
  logic [ODD_W-1:0] r1;
  logic [LOW-1:0]   sb_a;
  logic [LW-1:0]    q2;
  logic [ODD_W-1:0] r2;
  logic [SBB-1:0]   sb_b;

  // upper 19 bits first
  eutc_cdiv #(
    .XW(HI_W), .D(DAY_ODD), .QW(ODD_W), .RW(ODD_W), .SBW(LOW)
  ) u_div_hi (
    .clk_i (clk_i),
    .x_i   (t_i[EB-1 -: HI_W]),
    .sb_i  (t_i[LOW-1:0]),
    .q_o   (q1),
    .r_o   (r1),
    .sb_o  (sb_a)
  );

  // remainder joined with the lower bits
  eutc_cdiv #(
    .XW(ODD_W + LW), .D(DAY_ODD), .QW(LW), .RW(ODD_W), .SBW(SBB)
  ) u_div_lo (
    .clk_i (clk_i),
    .x_i   ({r1, sb_a[LOW-1:DAY_SHIFT]}),
    .sb_i  ({q1, sb_a[DAY_SHIFT-1:0]}),
    .q_o   (q2),
    .r_o   (r2),
    .sb_o  (sb_b)
  );

  assign days_o = {sb_b[SBB-1:DAY_SHIFT], q2};
  assign sod_o  = {r2, sb_b[DAY_SHIFT-1:0]};

endmodule

// File: rtl/core/eutc_tod.sv
// Second of day to hour, minute and second: divide by 60 as (sod >> 2) / 15,
// then minutes by 60.
module eutc_tod import eutc_pkg::*; (
  input  logic             clk_i,
  input  logic [SOD_W-1:0] sod_i,
  output tod_t             tod_o
);

  logic [10:0] mins;
  logic [3:0]  r15;
  logic [1:0]  sb_a;
  logic [4:0]  hours;
  logic [5:0]  min_r;
  logic [5:0]  sec_b;

  eutc_cdiv #(
    .XW(SOD_W - 2), .D(15), .QW(11), .RW(4), .SBW(2)
  ) u_div_min (
    .clk_i (clk_i),
    .x_i   (sod_i[SOD_W-1:2]),
    .sb_i  (sod_i[1:0]),
    .q_o   (mins),
    .r_o   (r15),
    .sb_o  (sb_a)
  );

  eutc_cdiv #(
    .XW(11), .D(60), .QW(5), .RW(6), .SBW(6)
  ) u_div_hour (
    .clk_i (clk_i),
    .x_i   (mins),
    .sb_i  ({r15, sb_a}),
    .q_o   (hours),
    .r_o   (min_r),
    .sb_o  (sec_b)
  );

  assign tod_o.hour   = hours;
  assign tod_o.minute = min_r;
  assign tod_o.second = sec_b;

endmodule

// File: rtl/core/eutc_civil.sv
// Day count to civil date: shift to 1600-03-01, split into 400-year,
// century, 4-year and year cycles, then map the day of the March-based year.
module eutc_civil import eutc_pkg::*; #(
  parameter int DW = 24
) (
  input  logic          clk_i,
  input  logic [DW-1:0] days_i,
  output date_t         date_o
);

  localparam int CW   = (DW + 1 > 18) ? DW + 1 : 18;
  localparam int ND   = (DW + 2) / 3;
  localparam int WSW  = $clog2(7 * ND + EPOCH_WDAY + 1);
  localparam int QYW  = CW - 16;
  localparam int YW   = QYW + 10;
  localparam int YFW  = (YW + 1 > 17) ? YW + 1 : 17;

  // weekday residue: 8 = 1 mod 7, so octal digits add up
  function automatic logic [2:0] mod7_fold(input logic [8:0] v);
    logic [4:0] f1;
    logic [3:0] f2;
    f1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]);
    f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
    return (f2 >= 4'(WEEK_DAYS)) ? 3'(f2 - 4'(WEEK_DAYS)) : 3'(f2);
  endfunction

  logic [ND*3-1:0] days_ext;
  logic [WSW-1:0]  wsum_d;
  logic [WSW-1:0]  wsum_q;
  logic [CW-1:0]   d_q;

  logic [QYW-1:0]  q400;
  logic [17:0]     r400;
  logic [WSW-1:0]  wsum_b;

  logic [2:0]      cent;
  logic [15:0]     rc;
  logic [QYW+2:0]  sb_c;
  logic [YW-1:0]   yacc_d;
  logic            c4_d;

  logic [4:0]      q4;
  logic [10:0]     r4;
  logic [YW+3:0]   sb_4;
  logic [YW-1:0]   yacc2_d;

  logic [2:0]      yrs;
  logic [8:0]      doy;
  logic [YW+3:0]   sb_y;

  logic [YW-1:0]   yacc_f;
  logic            c4_f;
  logic [3:0]      m_idx;
  logic            feb29;
  logic            wrap;
  logic [3:0]      mon;
  logic [4:0]      mday;
  logic [YFW-1:0]  ysum;

  // rebase to 1600-03-01, start the weekday digit sum
  assign days_ext = (ND*3)'(days_i);

  always_comb begin
    wsum_d = WSW'(EPOCH_WDAY);
    for (int k = 0; k < ND; k++) begin
      wsum_d = wsum_d + WSW'(days_ext[3*k +: 3]);
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= CW'(days_i) + CW'(DAYS_1600_TO_1970);
    wsum_q <= wsum_d;
  end

  // 400-year cycles
  eutc_cdiv #(
    .XW(CW), .D(DAYS_400Y), .QW(QYW), .RW(18), .SBW(WSW)
  ) u_div_400 (
    .clk_i (clk_i),
    .x_i   (d_q),
    .sb_i  (wsum_q),
    .q_o   (q400),
    .r_o   (r400),
    .sb_o  (wsum_b)
  );

  // centuries; a count of four is the leap day closing the cycle
  eutc_cdiv #(
    .XW(18), .D(DAYS_CENTURY), .QW(3), .RW(16), .SBW(QYW + 3)
  ) u_div_cen (
    .clk_i (clk_i),
    .x_i   (r400),
    .sb_i  ({q400, mod7_fold(9'(wsum_b))}),
    .q_o   (cent),
    .r_o   (rc),
    .sb_o  (sb_c)
  );

  assign yacc_d = YW'(sb_c[QYW+2:3]) * YW'(YEARS_PER_400) + YW'(cent) * YW'(YEARS_PER_CEN);
  assign c4_d   = cent == CENT_LEAP;

  // 4-year cycles
  eutc_cdiv #(
    .XW(16), .D(DAYS_4Y), .QW(5), .RW(11), .SBW(YW + 4)
  ) u_div_4y (
    .clk_i (clk_i),
    .x_i   (rc),
    .sb_i  ({yacc_d, c4_d, sb_c[2:0]}),
    .q_o   (q4),
    .r_o   (r4),
    .sb_o  (sb_4)
  );

  assign yacc2_d = sb_4[YW+3:4] + YW'({q4, 2'b00});

  // single years
  eutc_cdiv #(
    .XW(11), .D(DAYS_YEAR), .QW(3), .RW(9), .SBW(YW + 4)
  ) u_div_yr (
    .clk_i (clk_i),
    .x_i   (r4),
    .sb_i  ({yacc2_d, sb_4[3:0]}),
    .q_o   (yrs),
    .r_o   (doy),
    .sb_o  (sb_y)
  );

  // month lookup and final year
  assign yacc_f = sb_y[YW+3:4];
  assign c4_f   = sb_y[3];

  always_comb begin
    m_idx = '0;
    for (int k = 1; k < 12; k++) begin
      m_idx = m_idx + 4'(doy >= MONTH_START[k]);
    end
  end

  always_comb begin
    feb29 = c4_f || (yrs == YRS_LEAP);
    wrap  = m_idx >= JAN_WRAP;
    mon   = wrap ? m_idx - JAN_WRAP : m_idx + MARCH_OFS;
    mday  = 5'(doy - MONTH_START[m_idx] + 9'd1);
    if (feb29) begin
      wrap = 1'b0;
      mon  = MON_FEB;
      mday = LEAP_MDAY;
    end
    ysum = YFW'(yacc_f) + YFW'(yrs) + YFW'(wrap) - YFW'(YEAR_BIAS);
  end

  assign date_o.year  = (ysum > YFW'(YEAR_MAX)) ? YEAR_MAX : 16'(ysum);
  assign date_o.month = mon;
  assign date_o.mday  = mday;
  assign date_o.wday  = sb_y[2:0];

endmodule
